FILE: sv/desm_pkg.sv
// ----------------------------------------------------------------------------
// desm_pkg
// shared widths, codes and lane handshake types for the encoder speed block
// ----------------------------------------------------------------------------
`default_nettype none

package desm_pkg;

  localparam int DATA_W    = 32;
  localparam int CNT_W     = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 4;
  localparam int SCALE_W   = 10;
  localparam int PROD_W    = DATA_W + SCALE_W;
  localparam int STEP_W    = $clog2(PROD_W);

  localparam logic [SCALE_W-1:0] CPS_SCALE = SCALE_W'(1000);
  localparam logic [SCALE_W-1:0] RPM_SCALE = SCALE_W'(600);

  localparam logic [CFG_W-1:0] PERIOD_RESET = CFG_W'(10);
  localparam logic [CFG_W-1:0] CPR_RESET    = CFG_W'(0);

  localparam logic OP_UPDATE  = 1'b0;
  localparam logic OP_CAPTURE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CPR    = CFG_IDX_W'(1);

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] delta;
    logic [DATA_W-1:0] elapsed;
    logic [CFG_W-1:0]  cpr;
  } lane_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

endpackage

`default_nettype wire

FILE: sv/desm_lane.sv
// ----------------------------------------------------------------------------
// desm_lane
// one wheel: scale delta by 1000, divide by elapsed, scale by 600, divide by cpr
// ----------------------------------------------------------------------------
`default_nettype none

module desm_lane (
  input  logic                            clk,
  input  logic                            rst_n,
  input  desm_pkg::lane_cmd_t             cmd,
  input  logic                            ack,
  output desm_pkg::lane_stat_t            stat,
  output logic [desm_pkg::DATA_W-1:0]     cps,
  output logic [desm_pkg::DATA_W-1:0]     rpm
);
  import desm_pkg::*;

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_MUL  = 3'd1;
  localparam logic [2:0] L_DIV  = 3'd2;
  localparam logic [2:0] L_SIGN = 3'd3;
  localparam logic [2:0] L_DONE = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic              pass_r, pass_nxt;
  logic              neg_r, neg_nxt;
  logic [DATA_W-1:0] mag_r, mag_nxt;
  logic [DATA_W-1:0] div_r, div_nxt;
  logic [PROD_W-1:0] num_r, num_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CFG_W-1:0]  cpr_r, cpr_nxt;
  logic [DATA_W-1:0] cps_r, cps_nxt;
  logic [DATA_W-1:0] rpm_r, rpm_nxt;

  logic [SCALE_W-1:0] scale;
  logic [PROD_W-1:0]  prod;
  logic [DATA_W:0]    trial;
  logic [DATA_W:0]    trial_sub;
  logic               fits;
  logic [DATA_W-1:0]  quot;
  logic [DATA_W-1:0]  res;

  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
    mag32 = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
  endfunction

  always_comb begin
    scale     = pass_r ? RPM_SCALE : CPS_SCALE;
    prod      = PROD_W'(mag_r) * PROD_W'(scale);
    trial     = {rem_r, num_r[PROD_W-1]};
    trial_sub = trial - {1'b0, div_r};
    fits      = (trial >= {1'b0, div_r});
    quot      = num_r[DATA_W-1:0];
    res       = neg_r ? (~quot + DATA_W'(1)) : quot;
  end

  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    div_nxt   = div_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    cpr_nxt   = cpr_r;
    cps_nxt   = cps_r;
    rpm_nxt   = rpm_r;
    unique case (state_r)
      L_IDLE: begin
        if (cmd.start) begin
          mag_nxt   = mag32(cmd.delta);
          neg_nxt   = cmd.delta[DATA_W-1];
          div_nxt   = cmd.elapsed;
          cpr_nxt   = cmd.cpr;
          pass_nxt  = 1'b0;
          state_nxt = L_MUL;
        end
      end
      L_MUL: begin
        num_nxt   = prod;
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = L_DIV;
      end
      L_DIV: begin
        // restoring division, one quotient bit per cycle
        num_nxt  = {num_r[PROD_W-2:0], fits};
        rem_nxt  = fits ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(PROD_W - 1)) begin
          state_nxt = L_SIGN;
        end
      end
      L_SIGN: begin
        if (!pass_r) begin
          cps_nxt   = res;
          mag_nxt   = mag32(res);
          neg_nxt   = res[DATA_W-1];
          div_nxt   = DATA_W'(cpr_r);
          pass_nxt  = 1'b1;
          state_nxt = L_MUL;
        end else begin
          rpm_nxt   = res;
          state_nxt = L_DONE;
        end
      end
      L_DONE: begin
        if (ack) begin
          state_nxt = L_IDLE;
        end
      end
      default: begin
        state_nxt = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pass_r <= pass_nxt;
    neg_r  <= neg_nxt;
    mag_r  <= mag_nxt;
    div_r  <= div_nxt;
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    cpr_r  <= cpr_nxt;
    cps_r  <= cps_nxt;
    rpm_r  <= rpm_nxt;
  end

  assign stat.busy = (state_r != L_IDLE);
  assign stat.done = (state_r == L_DONE);
  assign cps       = cps_r;
  assign rpm       = rpm_r;

endmodule

`default_nettype wire

FILE: sv/desm_merge.sv
// ----------------------------------------------------------------------------
// desm_merge
// joins both lane results with deltas and elapsed time into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module desm_merge (
  input  logic                               clk,
  input  logic                               rst_n,
  input  desm_pkg::lane_stat_t               l_stat,
  input  desm_pkg::lane_stat_t               r_stat,
  input  logic [desm_pkg::DATA_W-1:0]        l_cps,
  input  logic [desm_pkg::DATA_W-1:0]        l_rpm,
  input  logic [desm_pkg::DATA_W-1:0]        r_cps,
  input  logic [desm_pkg::DATA_W-1:0]        r_rpm,
  input  logic [desm_pkg::DATA_W-1:0]        l_delta,
  input  logic [desm_pkg::DATA_W-1:0]        r_delta,
  input  logic [desm_pkg::DATA_W-1:0]        elapsed,
  output logic                               ack,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [desm_pkg::DATA_W-1:0] out_left_delta,
  output logic signed [desm_pkg::DATA_W-1:0] out_right_delta,
  output logic signed [desm_pkg::DATA_W-1:0] out_left_cps,
  output logic signed [desm_pkg::DATA_W-1:0] out_right_cps,
  output logic signed [desm_pkg::DATA_W-1:0] out_left_rpm_tenths,
  output logic signed [desm_pkg::DATA_W-1:0] out_right_rpm_tenths,
  output logic [desm_pkg::DATA_W-1:0]        out_elapsed
);
  import desm_pkg::*;

  logic              valid_r, valid_nxt;
  logic [DATA_W-1:0] ld_r, rd_r, lc_r, rc_r, lr_r, rr_r, el_r;

  assign ack = l_stat.done && r_stat.done && (!valid_r || out_ready);

  always_comb begin
    valid_nxt = valid_r;
    if (ack) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      ld_r <= l_delta;
      rd_r <= r_delta;
      lc_r <= l_cps;
      rc_r <= r_cps;
      lr_r <= l_rpm;
      rr_r <= r_rpm;
      el_r <= elapsed;
    end
  end

  assign out_valid            = valid_r;
  assign out_left_delta       = ld_r;
  assign out_right_delta      = rd_r;
  assign out_left_cps         = lc_r;
  assign out_right_cps        = rc_r;
  assign out_left_rpm_tenths  = lr_r;
  assign out_right_rpm_tenths = rr_r;
  assign out_elapsed          = el_r;

endmodule

`default_nettype wire

FILE: sv/dual_encoder_speed_estimator.sv
// ----------------------------------------------------------------------------
// dual_encoder_speed_estimator
// two-wheel encoder speed measurement: baseline capture, count deltas, counts
// per second and tenths of rpm from two parallel divide lanes
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid/in_ready    operation, left/right count, now_ms
//  out      out_valid/out_ready  deltas, cps, rpm tenths, elapsed
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
//  capture and rejected updates finish in the accept cycle, no result
//  a measured update holds the input until the lanes hand their result to the
//  merge register: per lane two 42-step restoring divides in series, each after
//  a constant multiply and followed by a sign fix
//  a stalled output holds the lanes in done until the merge register drains
//  reset is synchronous, active low; baseline clears to zero
// ----------------------------------------------------------------------------
`default_nettype none

module dual_encoder_speed_estimator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_operation,
  input  logic signed [desm_pkg::DATA_W-1:0]  in_left_count,
  input  logic signed [desm_pkg::DATA_W-1:0]  in_right_count,
  input  logic [desm_pkg::DATA_W-1:0]         in_now_ms,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [desm_pkg::DATA_W-1:0]  out_left_delta,
  output logic signed [desm_pkg::DATA_W-1:0]  out_right_delta,
  output logic signed [desm_pkg::DATA_W-1:0]  out_left_cps,
  output logic signed [desm_pkg::DATA_W-1:0]  out_right_cps,
  output logic signed [desm_pkg::DATA_W-1:0]  out_left_rpm_tenths,
  output logic signed [desm_pkg::DATA_W-1:0]  out_right_rpm_tenths,
  output logic [desm_pkg::DATA_W-1:0]         out_elapsed,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [desm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [desm_pkg::CFG_W-1:0]          cfg_data
);
  import desm_pkg::*;

  logic [CFG_W-1:0]  period_r, period_nxt;
  logic [CFG_W-1:0]  cpr_r, cpr_nxt;
  logic [DATA_W-1:0] base_left_r, base_left_nxt;
  logic [DATA_W-1:0] base_right_r, base_right_nxt;
  logic [DATA_W-1:0] base_time_r, base_time_nxt;
  logic [DATA_W-1:0] ldelta_r, rdelta_r, el_r;

  logic                     accept;
  logic                     sample_ok;
  logic                     start;
  logic                     load_base;
  logic                     cfg_wr;
  logic [DATA_W-1:0]        el;
  logic signed [CNT_W-1:0]  ldiff, rdiff;
  logic [DATA_W-1:0]        ldelta, rdelta;
  lane_cmd_t                l_cmd, r_cmd;
  lane_stat_t               l_stat, r_stat;
  logic [DATA_W-1:0]        l_cps, l_rpm, r_cps, r_rpm;
  logic                     ack;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_ready  = !l_stat.busy && !r_stat.busy;
  assign accept    = in_valid && in_ready;

  always_comb begin
    el        = in_now_ms - base_time_r;
    sample_ok = (el != '0) && (el >= DATA_W'(period_r)) && (cpr_r != '0);
    start     = accept && (in_operation == OP_UPDATE) && sample_ok;
    load_base = accept && ((in_operation == OP_CAPTURE) || sample_ok);
    ldiff     = in_left_count[CNT_W-1:0] - base_left_r[CNT_W-1:0];
    rdiff     = in_right_count[CNT_W-1:0] - base_right_r[CNT_W-1:0];
    ldelta    = DATA_W'(ldiff);
    rdelta    = DATA_W'(rdiff);
  end

  always_comb begin
    period_nxt = period_r;
    cpr_nxt    = cpr_r;
    if (cfg_wr) begin
      unique case (cfg_index)
        REG_PERIOD: begin
          period_nxt = cfg_data;
        end
        REG_CPR: begin
          cpr_nxt = cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    base_left_nxt  = base_left_r;
    base_right_nxt = base_right_r;
    base_time_nxt  = base_time_r;
    if (load_base) begin
      base_left_nxt  = in_left_count;
      base_right_nxt = in_right_count;
      base_time_nxt  = in_now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r     <= PERIOD_RESET;
      cpr_r        <= CPR_RESET;
      base_left_r  <= '0;
      base_right_r <= '0;
      base_time_r  <= '0;
    end else begin
      period_r     <= period_nxt;
      cpr_r        <= cpr_nxt;
      base_left_r  <= base_left_nxt;
      base_right_r <= base_right_nxt;
      base_time_r  <= base_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ldelta_r <= ldelta;
      rdelta_r <= rdelta;
      el_r     <= el;
    end
  end

  always_comb begin
    l_cmd.start   = start;
    l_cmd.delta   = ldelta;
    l_cmd.elapsed = el;
    l_cmd.cpr     = cpr_r;
    r_cmd.start   = start;
    r_cmd.delta   = rdelta;
    r_cmd.elapsed = el;
    r_cmd.cpr     = cpr_r;
  end

  desm_lane u_lane_l (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (l_cmd),
    .ack   (ack),
    .stat  (l_stat),
    .cps   (l_cps),
    .rpm   (l_rpm)
  );

  desm_lane u_lane_r (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (r_cmd),
    .ack   (ack),
    .stat  (r_stat),
    .cps   (r_cps),
    .rpm   (r_rpm)
  );

  desm_merge u_merge (
    .clk                  (clk),
    .rst_n                (rst_n),
    .l_stat               (l_stat),
    .r_stat               (r_stat),
    .l_cps                (l_cps),
    .l_rpm                (l_rpm),
    .r_cps                (r_cps),
    .r_rpm                (r_rpm),
    .l_delta              (ldelta_r),
    .r_delta              (rdelta_r),
    .elapsed              (el_r),
    .ack                  (ack),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_left_delta       (out_left_delta),
    .out_right_delta      (out_right_delta),
    .out_left_cps         (out_left_cps),
    .out_right_cps        (out_right_cps),
    .out_left_rpm_tenths  (out_left_rpm_tenths),
    .out_right_rpm_tenths (out_right_rpm_tenths),
    .out_elapsed          (out_elapsed)
  );

`ifndef SYNTHESIS
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (l_stat.busy == r_stat.busy) && (l_stat.done == r_stat.done))
    else $error("lanes out of step");

  a_result_from_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(l_stat.done && r_stat.done))
    else $error("result without finished lanes");

  a_capture_no_work: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_operation == OP_CAPTURE)) |=> !l_stat.busy)
    else $error("capture started a lane");

  a_zero_cpr_no_work: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (cpr_r == '0)) |=> !l_stat.busy)
    else $error("lane started with zero counts per revolution");
`endif

endmodule

`default_nettype wire

FILE: bench/tb_dual_encoder_speed_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_encoder_speed_estimator
// self-checking bench: a directed table of extremes and rejected updates, then
// random encoder sample streams under several register settings, with random
// stalls on both channels; every result is checked field by field against a
// typed expectation from the table or a bit-accurate speed predictor in the bench
// ----------------------------------------------------------------------------
module tb_dual_encoder_speed_estimator;
  import desm_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 120;
  localparam int TAIL_CYCLES    = 200;
  localparam int DIR_N          = 24;

  typedef logic [0:6][DATA_W-1:0] speed_vec_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {PRED_MODEL, PRED_TYPED, PRED_NONE} pred_src_t;

  typedef struct packed {
    row_kind_t              kind;
    pred_src_t              src;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_W-1:0]       data;
    logic                   op;
    logic [DATA_W-1:0]      lc;
    logic [DATA_W-1:0]      rc;
    logic [DATA_W-1:0]      now;
    speed_vec_t             want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_operation = OP_UPDATE;
  logic signed [DATA_W-1:0] in_left_count = '0;
  logic signed [DATA_W-1:0] in_right_count = '0;
  logic [DATA_W-1:0] in_now_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_left_delta;
  logic signed [DATA_W-1:0] out_right_delta;
  logic signed [DATA_W-1:0] out_left_cps;
  logic signed [DATA_W-1:0] out_right_cps;
  logic signed [DATA_W-1:0] out_left_rpm_tenths;
  logic signed [DATA_W-1:0] out_right_rpm_tenths;
  logic [DATA_W-1:0] out_elapsed;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // sideband that travels with each input transaction
  pred_src_t  row_src = PRED_MODEL;
  speed_vec_t row_want = '0;

  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int err_cnt = 0;
  int idle_cycles = 0;

  speed_vec_t speed_q[$];

  logic [CFG_W-1:0]  period_reg = PERIOD_RESET;
  logic [CFG_W-1:0]  cpr_reg = CPR_RESET;
  logic [DATA_W-1:0] base_left = '0;
  logic [DATA_W-1:0] base_right = '0;
  logic [DATA_W-1:0] base_time = '0;

  string fld_name [7] = '{"left_delta", "right_delta", "left_cps", "right_cps",
                          "left_rpm_tenths", "right_rpm_tenths", "elapsed"};

  stim_row_t dir_tab [DIR_N] = '{
    '{ROW_ITEM, PRED_NONE, 4'd0, 16'd0, OP_UPDATE, 32'd5, 32'd7, 32'd100, '0},
    '{ROW_CFG, PRED_NONE, REG_CPR, 16'd1000, OP_UPDATE, 32'd0, 32'd0, 32'd0, '0},
    '{ROW_ITEM, PRED_TYPED, 4'd0, 16'd0, OP_UPDATE, 32'd0, 32'd0, 32'd100,
      '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd100}},
    '{ROW_ITEM, PRED_NONE, 4'd0, 16'd0, OP_UPDATE, 32'd0, 32'd0, 32'd100, '0},
    '{ROW_ITEM, PRED_NONE, 4'd0, 16'd0, OP_UPDATE, 32'd0, 32'd0, 32'd105, '0},
    '{ROW_ITEM, PRED_TYPED, 4'd0, 16'd0, OP_UPDATE, 32'd100, -32'sd100, 32'd110,
      '{32'd100, -32'sd100, 32'd10000, -32'sd10000, 32'd6000, -32'sd6000, 32'd10}},
    '{ROW_ITEM, PRED_NONE, 4'd0, 16'd0, OP_CAPTURE, 32'h7fff_ffff, 32'h8000_0000,
      32'hffff_ffff, '0},
    '{ROW_ITEM, PRED_TYPED, 4'd0, 16'd0, OP_UPDATE, 32'h8000_0000, 32'h7fff_ffff, 32'd9,
      '{32'd1, -32'sd1, 32'd100, -32'sd100, 32'd60, -32'sd60, 32'd10}},
    '{ROW_CFG, PRED_NONE, REG_PERIOD, 16'd0, OP_UPDATE, 32'd0, 32'd0, 32'd0, '0},
    '{ROW_CFG, PRED_NONE, REG_CPR, 16'd1, OP_UPDATE, 32'd0, 32'd0, 32'd0, '0},
    '{ROW_CFG, PRED_NONE, 4'hf, 16'ha5c3, OP_UPDATE, 32'd0, 32'd0, 32'd0, '0},
    '{ROW_ITEM, PRED_NONE, 4'd0, 16'd0, OP_CAPTURE, 32'd0, 32'd0, 32'd0, '0},
    '{ROW_ITEM, PRED_TYPED, 4'd0, 16'd0, OP_UPDATE, 32'h7fff_ffff, 32'h8000_0000, 32'd1,
      '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_fc18, 32'd0, 32'hfff6_d840, 32'd0,
        32'd1}},
    '{ROW_ITEM, PRED_NONE, 4'd0, 16'd0, OP_UPDATE, 32'h7fff_ffff, 32'h8000_0000, 32'd1,
      '0},
    '{ROW_ITEM, PRED_MODEL, 4'd0, 16'd0, OP_UPDATE, 32'd0, 32'd0, 32'd0, '0},
    '{ROW_CFG, PRED_NONE, REG_PERIOD, 16'hffff, OP_UPDATE, 32'd0, 32'd0, 32'd0, '0},
    '{ROW_CFG, PRED_NONE, REG_CPR, 16'hffff, OP_UPDATE, 32'd0, 32'd0, 32'd0, '0},
    '{ROW_ITEM, PRED_NONE, 4'd0, 16'd0, OP_UPDATE, 32'd1234, -32'sd999, 32'd65534, '0},
    '{ROW_ITEM, PRED_MODEL, 4'd0, 16'd0, OP_UPDATE, 32'h8000_0000, 32'h7fff_ffff,
      32'd65535, '0},
    '{ROW_ITEM, PRED_NONE, 4'd0, 16'd0, OP_CAPTURE, 32'hffff_ffff, 32'hffff_ffff, 32'd1,
      '0},
    '{ROW_ITEM, PRED_MODEL, 4'd0, 16'd0, OP_UPDATE, 32'd0, 32'd0, 32'd65536, '0},
    '{ROW_CFG, PRED_NONE, REG_PERIOD, 16'd1, OP_UPDATE, 32'd0, 32'd0, 32'd0, '0},
    '{ROW_CFG, PRED_NONE, REG_CPR, 16'd3, OP_UPDATE, 32'd0, 32'd0, 32'd0, '0},
    '{ROW_ITEM, PRED_MODEL, 4'd0, 16'd0, OP_UPDATE, 32'h8000_0000, 32'h7fff_ffff,
      32'd65537, '0}
  };

  dual_encoder_speed_estimator uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_left_count       (in_left_count),
    .in_right_count      (in_right_count),
    .in_now_ms           (in_now_ms),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_left_delta      (out_left_delta),
    .out_right_delta     (out_right_delta),
    .out_left_cps        (out_left_cps),
    .out_right_cps       (out_right_cps),
    .out_left_rpm_tenths (out_left_rpm_tenths),
    .out_right_rpm_tenths(out_right_rpm_tenths),
    .out_elapsed         (out_elapsed),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint wrap_word(input longint x);
    logic signed [DATA_W-1:0] w;
    w = x[DATA_W-1:0];
    return longint'(w);
  endfunction

  // m-method speed sample; moves the baseline on capture and on a valid update
  function automatic bit measure_speed(input logic op, input logic [DATA_W-1:0] lc,
                                       input logic [DATA_W-1:0] rc,
                                       input logic [DATA_W-1:0] now,
                                       output speed_vec_t r);
    logic [DATA_W-1:0] el;
    logic signed [DATA_W-1:0] dl, dr;
    longint ld, rd, lcps, rcps, lrpm, rrpm, el64, cpr64;
    r = '0;
    if (op == OP_CAPTURE) begin
      base_left = lc;
      base_right = rc;
      base_time = now;
      return 1'b0;
    end
    el = now - base_time;
    if (el == '0 || el < {16'd0, period_reg} || cpr_reg == '0) return 1'b0;
    dl = lc - base_left;
    dr = rc - base_right;
    ld = longint'(dl);
    rd = longint'(dr);
    el64 = longint'({32'd0, el});
    cpr64 = longint'({48'd0, cpr_reg});
    lcps = wrap_word((ld * 1000) / el64);
    rcps = wrap_word((rd * 1000) / el64);
    lrpm = wrap_word((lcps * 600) / cpr64);
    rrpm = wrap_word((rcps * 600) / cpr64);
    r = {ld[31:0], rd[31:0], lcps[31:0], rcps[31:0], lrpm[31:0], rrpm[31:0], el};
    base_left = lc;
    base_right = rc;
    base_time = now;
    return 1'b1;
  endfunction

  function automatic logic [DATA_W-1:0] pick_delta();
    logic [DATA_W-1:0] d;
    case ($urandom_range(0, 4))
      0, 1, 2: d = $urandom_range(0, 4000) - 2000;
      3: d = $urandom;
      default: d = $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 1000)
                                        : 32'h8000_0000 + $urandom_range(0, 1000);
    endcase
    return d;
  endfunction

  task automatic send_item(input logic op, input logic [DATA_W-1:0] lc,
                           input logic [DATA_W-1:0] rc, input logic [DATA_W-1:0] now,
                           input pred_src_t src, input speed_vec_t want);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_left_count <= lc;
    in_right_count <= rc;
    in_now_ms <= now;
    row_src <= src;
    row_want <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  // registers change only once the block has drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (speed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  always @(posedge clk) begin : scoreboard
    speed_vec_t seen, want_v, pred;
    bit hit;
    if (!rst_n) begin
      period_reg = PERIOD_RESET;
      cpr_reg = CPR_RESET;
      base_left = '0;
      base_right = '0;
      base_time = '0;
    end else begin
      if (out_valid && out_ready) begin
        seen = {out_left_delta, out_right_delta, out_left_cps, out_right_cps,
                out_left_rpm_tenths, out_right_rpm_tenths, out_elapsed};
        if (speed_q.size() == 0) begin
          err_cnt++;
          $display("%0t unexpected result: expected none, got %h", $time, seen);
        end else begin
          want_v = speed_q.pop_front();
          for (int i = 0; i < 7; i++) begin
            if (seen[i] !== want_v[i]) begin
              err_cnt++;
              $display("%0t %s mismatch: expected %h, got %h", $time, fld_name[i],
                       want_v[i], seen[i]);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PERIOD: period_reg = cfg_data;
          REG_CPR: cpr_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        hit = measure_speed(in_operation, in_left_count, in_right_count, in_now_ms, pred);
        case (row_src)
          PRED_MODEL: if (hit) speed_q.push_back(pred);
          PRED_TYPED: speed_q.push_back(row_want);
          default: ;
        endcase
      end
    end
  end

  // no transaction on any channel for too long means a hang
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("dual_encoder_speed_estimator verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [DATA_W-1:0] t_last, l_last, r_last, lc, rc, now, step;
    logic op;
    int ph_period, ph_cpr, n;
    t_last = '0;
    l_last = '0;
    r_last = '0;
    in_idle_pct = 9;
    out_idle_pct = 86;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_item(dir_tab[i].op, dir_tab[i].lc, dir_tab[i].rc, dir_tab[i].now,
                  dir_tab[i].src, dir_tab[i].want);
        t_last = dir_tab[i].now;
        l_last = dir_tab[i].lc;
        r_last = dir_tab[i].rc;
      end
    end

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin ph_period = 10; ph_cpr = 1000; end
        1: begin ph_period = 0; ph_cpr = 1; end
        2: begin ph_period = 65535; ph_cpr = 65535; end
        3: begin ph_period = $urandom_range(0, 65535); ph_cpr = $urandom_range(1, 65535); end
        4: begin ph_period = $urandom_range(1, 50); ph_cpr = $urandom_range(1, 4096); end
        5: begin ph_period = 1; ph_cpr = 0; end
        default: begin
          ph_period = $urandom_range(0, 200);
          ph_cpr = $urandom_range(1, 65535);
        end
      endcase
      in_idle_pct = (p < 2) ? 9 : (p < 4) ? 86 : 0;
      out_idle_pct = (p < 2) ? 86 : (p < 4) ? 9 : 0;
      write_reg(REG_PERIOD, ph_period[CFG_W-1:0]);
      write_reg(REG_CPR, ph_cpr[CFG_W-1:0]);
      n = (p == 5) ? 30 : 100;
      repeat (n) begin
        if ($urandom_range(0, 99) < 5) begin
          lc = $urandom;
          rc = $urandom;
          now = $urandom;
        end else begin
          lc = l_last + pick_delta();
          rc = r_last + pick_delta();
          case ($urandom_range(0, 9))
            7: step = '0;
            8: step = (ph_period == 0) ? '0 : $urandom_range(0, ph_period - 1);
            9: step = $urandom;
            default: step = ph_period + $urandom_range(0, 300);
          endcase
          now = t_last + step;
        end
        op = ($urandom_range(0, 99) < 12) ? OP_CAPTURE : OP_UPDATE;
        send_item(op, lc, rc, now, PRED_MODEL, '0);
        t_last = now;
        l_last = lc;
        r_last = rc;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (speed_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (speed_q.size() != 0) begin
      err_cnt++;
      $display("%0t %0d expected results never arrived", $time, speed_q.size());
    end
    if (err_cnt == 0) begin
      $display("dual_encoder_speed_estimator verification clean");
    end else begin
      $display("dual_encoder_speed_estimator verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/desm_pkg.sv
sv/desm_lane.sv
sv/desm_merge.sv
sv/dual_encoder_speed_estimator.sv
bench/tb_dual_encoder_speed_estimator.sv
